>>> rtl/sm4_block_encrypt_swapped_sbox_assert.svh
// Assertion macros for the RTL of the SM4 block.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef SM4_BLOCK_ENCRYPT_SWAPPED_SBOX_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_SWAPPED_SBOX_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequence must hold in the same cycle as the condition.
`define SM4_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("SM4 same-cycle check failed");
// The consequence must hold in the cycle after the condition.
`define SM4_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("SM4 next-cycle check failed");
`else
`define SM4_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SM4_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/sm4_pkg.sv
package sm4_pkg;

    localparam int ROUNDS = 32;
    localparam int WORD_W = 32;
    localparam int BLOCK_W = 128;
    localparam int HALF_W = 64;
    localparam int CFG_INDEX_W = 1;

    typedef logic [WORD_W-1:0] word_t;
    // Four state words, element 0 is the oldest word of the sliding window.
    typedef word_t [3:0] quad_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    // Table positions that trade places in this variant of the S-box.
    localparam logic [7:0] SWAP_A_LO = 8'h3A;
    localparam logic [7:0] SWAP_A_HI = 8'h7F;
    localparam logic [7:0] SWAP_B_LO = 8'hB2;
    localparam logic [7:0] SWAP_B_HI = 8'hE8;

    localparam logic [7:0] SBOX_TABLE [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [7:0] sbox_byte(input logic [7:0] b);
        logic [7:0] idx;
        idx = b;
        if (b == SWAP_A_LO) begin
            idx = SWAP_A_HI;
        end else if (b == SWAP_A_HI) begin
            idx = SWAP_A_LO;
        end else if (b == SWAP_B_LO) begin
            idx = SWAP_B_HI;
        end else if (b == SWAP_B_HI) begin
            idx = SWAP_B_LO;
        end
        return SBOX_TABLE[idx];
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {sbox_byte(w[31:24]), sbox_byte(w[23:16]), sbox_byte(w[15:8]), sbox_byte(w[7:0])};
    endfunction

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic word_t lin_data(input word_t b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic word_t lin_key(input word_t b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // Round constant: byte j of word i is 7 * (4i + j) modulo 256, high byte first.
    function automatic word_t ck_word(input int unsigned i);
        word_t v;
        v = '0;
        for (int unsigned j = 0; j < 4; j++) begin
            v = {v[23:0], 8'(((4 * i) + j) * 7)};
        end
        return v;
    endfunction

    // Next round key from the current key window.
    function automatic word_t key_round(input quad_t k, input word_t ck);
        return k[0] ^ lin_key(sub_word(k[1] ^ k[2] ^ k[3] ^ ck));
    endfunction

    // Next data word from the current data window and round key.
    function automatic word_t data_round(input quad_t x, input word_t rk);
        return x[0] ^ lin_data(sub_word(x[1] ^ x[2] ^ x[3] ^ rk));
    endfunction

endpackage

>>> rtl/sm4_block_encrypt_swapped_sbox.sv
// Throughput: one 128-bit block per cycle while the output is not stalled; the round
// pipeline has one register stage per round plus a key-expansion stage in front, and each
// stage holds at most one block.
// Reset: aresetn is synchronous and active low; it clears every stage valid bit and both
// key registers. Data registers are not reset.
`include "sm4_block_encrypt_swapped_sbox_assert.svh"

module sm4_block_encrypt_swapped_sbox #(
    parameter int ROUNDS = sm4_pkg::ROUNDS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Key register write port.
    input  logic                            cfg_wr_en,
    input  logic [sm4_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [sm4_pkg::HALF_W-1:0]      cfg_wr_data,
    // Plaintext stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0 up: block_high [63:0], block_low [127:64].
    input  logic [sm4_pkg::BLOCK_W-1:0]     s_tdata,
    // Ciphertext stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: cipher_high [63:0], cipher_low [127:64].
    output logic [sm4_pkg::BLOCK_W-1:0]     m_tdata
);
    import sm4_pkg::*;

    // The design has ROUNDS + 1 register stages. Stage 0 loads the plaintext and derives
    // the first round key from the key registers. Stage s (1 to ROUNDS) applies data
    // round s - 1 with the round key that stage s - 1 registered, and, for s below ROUNDS,
    // at the same time derives round key s from the key window that travels along with
    // the block. Since every block carries its own key window, a new key takes effect
    // with the very next block, and no key expansion ahead of time is needed. Stage
    // ROUNDS is the output register.

    localparam int LAST = ROUNDS;

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;

    logic [LAST:0] valid_reg;
    logic [LAST:0] valid_next;
    logic [LAST:0] stage_ready;

    quad_t x_reg  [0:LAST];
    quad_t k_reg  [0:LAST-1];
    word_t rk_reg [0:LAST-1];

    quad_t k_init;
    word_t rk_init;
    quad_t x_init;

    // Key registers. An index that names no register is not possible with a one-bit index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_KEY_HIGH: key_high_reg <= cfg_wr_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Backpressure: a stage takes new contents when it is empty or when its own contents
    // move on in the same cycle. A bubble anywhere in the pipeline therefore keeps the
    // input side open even while the output transfer is stalled.
    assign stage_ready[LAST] = !valid_reg[LAST] || m_tready;
    for (genvar s = 0; s < LAST; s++) begin : g_ready
        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
    end

    assign valid_next[0] = stage_ready[0] ? s_tvalid : valid_reg[0];
    for (genvar s = 1; s <= LAST; s++) begin : g_valid
        assign valid_next[s] = stage_ready[s] ? valid_reg[s-1] : valid_reg[s];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0: plaintext words and the first key window after the FK whitening.
    assign x_init[0] = s_tdata[HALF_W-1:WORD_W];
    assign x_init[1] = s_tdata[WORD_W-1:0];
    assign x_init[2] = s_tdata[BLOCK_W-1:HALF_W+WORD_W];
    assign x_init[3] = s_tdata[HALF_W+WORD_W-1:HALF_W];

    assign k_init[0] = key_high_reg[HALF_W-1:WORD_W] ^ FK0;
    assign k_init[1] = key_high_reg[WORD_W-1:0] ^ FK1;
    assign k_init[2] = key_low_reg[HALF_W-1:WORD_W] ^ FK2;
    assign k_init[3] = key_low_reg[WORD_W-1:0] ^ FK3;

    assign rk_init = key_round(k_init, ck_word(0));

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            x_reg[0]  <= x_init;
            k_reg[0]  <= {rk_init, k_init[3], k_init[2], k_init[1]};
            rk_reg[0] <= rk_init;
        end
    end

    // Round stages.
    for (genvar s = 1; s <= LAST; s++) begin : g_round
        word_t t_word;
        assign t_word = data_round(x_reg[s-1], rk_reg[s-1]);

        always_ff @(posedge aclk) begin
            if (stage_ready[s]) begin
                x_reg[s] <= {t_word, x_reg[s-1][3], x_reg[s-1][2], x_reg[s-1][1]};
            end
        end

        if (s < LAST) begin : g_key
            word_t rk_word;
            assign rk_word = key_round(k_reg[s-1], ck_word(s));

            always_ff @(posedge aclk) begin
                if (stage_ready[s]) begin
                    k_reg[s]  <= {rk_word, k_reg[s-1][3], k_reg[s-1][2], k_reg[s-1][1]};
                    rk_reg[s] <= rk_word;
                end
            end
        end
    end

    // The ciphertext is the final data window in reverse word order.
    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {x_reg[LAST][1], x_reg[LAST][0], x_reg[LAST][3], x_reg[LAST][2]};

    // An accepted block always lands in the first stage.
    `SM4_ASSERT_NEXT(a_input_lands, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
    // Any empty stage keeps the input side open.
    `SM4_ASSERT_SAME(a_bubble_opens_input, aclk, aresetn, !(&valid_reg), s_tready)
    // A full pipeline with a stalled output closes the input side.
    `SM4_ASSERT_SAME(a_full_stalls_input, aclk, aresetn,
                     ($countones(valid_reg) == LAST + 1) && !m_tready, !s_tready)
    // A stalled output block stays valid, and the stage in front of it stays full.
    `SM4_ASSERT_NEXT(a_stall_keeps_tail, aclk, aresetn,
                     m_tvalid && !m_tready && valid_reg[LAST-1],
                     m_tvalid && valid_reg[LAST-1])

endmodule
